@@ rtl/cfd_pkg.sv @@
// shared types, codes and the crc-8 byte update for the frame deframer
// no dependencies
package cfd_pkg;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [3:0] ST_BUSY     = 4'd0;
   localparam logic [3:0] ST_ACCEPT   = 4'd1;
   localparam logic [3:0] ST_IGNORED  = 4'd2;
   localparam logic [3:0] ST_BAD_LEN  = 4'd3;
   localparam logic [3:0] ST_HDR_CRC  = 4'd4;
   localparam logic [3:0] ST_NO_DATA  = 4'd5;
   localparam logic [3:0] ST_OVERFLOW = 4'd6;
   localparam logic [3:0] ST_PKT_CRC  = 4'd7;
   localparam logic [3:0] ST_NO_END   = 4'd8;
   localparam logic [3:0] ST_READ     = 4'd9;

   localparam logic [2:0] REG_START_MARKER  = 3'd0;
   localparam logic [2:0] REG_DATA_MARKER   = 3'd1;
   localparam logic [2:0] REG_END_MARKER    = 3'd2;
   localparam logic [2:0] REG_MIN_FRAME_LEN = 3'd3;
   localparam logic [2:0] REG_MAX_FRAME_LEN = 3'd4;
   localparam logic [2:0] REG_CRC_POLY      = 3'd5;
   localparam logic [2:0] REG_CRC_INIT      = 3'd6;

   localparam logic [15:0] MIN_FRAME_LEN_RESET = 16'd4;
   localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd259;
   localparam logic [7:0]  CRC_POLY_RESET      = 8'h07;
   localparam logic [7:0]  CRC_INIT_RESET      = 8'h00;

   // data marker, packet crc and end marker in the length field
   localparam logic [15:0] FRAME_OVERHEAD = 16'd3;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [7:0]  data_marker;
      logic [7:0]  end_marker;
      logic [15:0] min_frame_len;
      logic [15:0] max_frame_len;
      logic [7:0]  crc_poly;
      logic [7:0]  crc_init;
   } cfd_cfg_type;

   typedef struct packed {
      logic [3:0] status;
      logic [8:0] frame_len;
      logic       hit;
   } cfd_result_type;

   function automatic logic [7:0] cfd_crc8_step(input logic [7:0] crc,
                                                input logic [7:0] rx,
                                                input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ rx;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/cfd_channels_if.sv @@
// valid/ready channel interfaces for requests, responses and register writes
// depends on nothing
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;
   logic [7:0] read_index;
   modport source (output valid, req_type, rx_byte, read_index, input ready);
   modport sink (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [8:0] frame_len;
   logic [7:0] read_data;
   modport source (output valid, status, frame_len, read_data, input ready);
   modport sink (input valid, status, frame_len, read_data, output ready);
endinterface

interface cfd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/crc8_frame_deframer_unit.sv @@
// Frame deframer: takes one beat per cycle, either a received byte or a read of the
// payload buffer, and gives exactly one response beat for each. A new beat is taken
// every cycle while the response side keeps up; each response passes through the
// registered read of the single-port payload buffer and then the output register.
// Configuration registers are written through the csr channel (always ready) and
// must only change while no request is outstanding.
// depends on cfd_pkg, cfd_channels_if, cfd_csr_regs, cfd_parser, cfd_payload_ram
module crc8_frame_deframer_unit #(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   cfd_req_if.sink req,
   cfd_rsp_if.source rsp,
   cfd_csr_if.sink csr
);
   import cfd_pkg::*;

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

   cfd_cfg_type    cfg;
   cfd_result_type result;
   logic           accept;
   logic           s1_adv;
   logic           mem_wr_en;
   logic           mem_rd_en;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wdata;
   logic [7:0]     mem_rdata;

   logic           s1_valid_ff, s1_valid_in;
   cfd_result_type s1_result_ff;
   logic           s2_valid_ff, s2_valid_in;
   logic [3:0]     s2_status_ff;
   logic [8:0]     s2_frame_len_ff;
   logic [7:0]     s2_read_data_ff;

   assign s1_adv    = !s2_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   cfd_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   cfd_parser #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .AW            (AW),
      .CW            (CW)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req.req_type),
      .rx_byte    (req.rx_byte),
      .read_index (req.read_index),
      .cfg        (cfg),
      .result     (result),
      .mem_wr_en  (mem_wr_en),
      .mem_rd_en  (mem_rd_en),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata)
   );

   cfd_payload_ram #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .AW            (AW)
   ) u_payload_ram (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= result;
      end
      if (s1_adv && s1_valid_ff) begin
         s2_status_ff    <= s1_result_ff.status;
         s2_frame_len_ff <= s1_result_ff.frame_len;
         s2_read_data_ff <= s1_result_ff.hit ? mem_rdata : 8'd0;
      end
   end

   assign rsp.valid     = s2_valid_ff;
   assign rsp.status    = s2_status_ff;
   assign rsp.frame_len = s2_frame_len_ff;
   assign rsp.read_data = s2_read_data_ff;

endmodule

@@ rtl/cfd_csr_regs.sv @@
// configuration registers written over the csr channel
// depends on cfd_pkg and cfd_channels_if
module cfd_csr_regs (
   input  logic                clock,
   input  logic                reset,
   cfd_csr_if.sink             csr,
   output cfd_pkg::cfd_cfg_type cfg
);
   import cfd_pkg::*;

   cfd_cfg_type cfg_ff;
   cfd_cfg_type cfg_in;
   logic        wr_en;

   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr.index)
            REG_START_MARKER:  cfg_in.start_marker  = csr.data[7:0];
            REG_DATA_MARKER:   cfg_in.data_marker   = csr.data[7:0];
            REG_END_MARKER:    cfg_in.end_marker    = csr.data[7:0];
            REG_MIN_FRAME_LEN: cfg_in.min_frame_len = csr.data;
            REG_MAX_FRAME_LEN: cfg_in.max_frame_len = csr.data;
            REG_CRC_POLY:      cfg_in.crc_poly      = csr.data[7:0];
            REG_CRC_INIT:      cfg_in.crc_init      = csr.data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= 8'd0;
         cfg_ff.data_marker   <= 8'd0;
         cfg_ff.end_marker    <= 8'd0;
         cfg_ff.min_frame_len <= MIN_FRAME_LEN_RESET;
         cfg_ff.max_frame_len <= MAX_FRAME_LEN_RESET;
         cfg_ff.crc_poly      <= CRC_POLY_RESET;
         cfg_ff.crc_init      <= CRC_INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/cfd_payload_ram.sv @@
// single-port payload buffer, registered read data held until the next read
// depends on nothing
module cfd_payload_ram #(
   parameter int PAYLOAD_DEPTH = 256,
   parameter int AW            = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] mem [PAYLOAD_DEPTH];
   logic [7:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

@@ rtl/cfd_parser.sv @@
// frame parser: phase, length, crcs and counts; drives the payload buffer port
// depends on cfd_pkg
module cfd_parser #(
   parameter int PAYLOAD_DEPTH = 256,
   parameter int AW            = 8,
   parameter int CW            = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    req_type,
   input  logic [7:0]              rx_byte,
   input  logic [7:0]              read_index,
   input  cfd_pkg::cfd_cfg_type    cfg,
   output cfd_pkg::cfd_result_type result,
   output logic                    mem_wr_en,
   output logic                    mem_rd_en,
   output logic [AW-1:0]           mem_addr,
   output logic [7:0]              mem_wdata
);
   import cfd_pkg::*;

   localparam logic [2:0] PH_HUNT      = 3'd0;
   localparam logic [2:0] PH_LEN_LO    = 3'd1;
   localparam logic [2:0] PH_LEN_HI    = 3'd2;
   localparam logic [2:0] PH_HDR_CRC   = 3'd3;
   localparam logic [2:0] PH_DATA_MARK = 3'd4;
   localparam logic [2:0] PH_PAYLOAD   = 3'd5;
   localparam logic [2:0] PH_PKT_CRC   = 3'd6;
   localparam logic [2:0] PH_END       = 3'd7;
   localparam logic [15:0] DEPTH16     = 16'(PAYLOAD_DEPTH);

   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    length_low_ff, length_low_in;
   logic [15:0]   frame_length_ff, frame_length_in;
   logic [7:0]    header_crc_ff, header_crc_in;
   logic [7:0]    packet_crc_ff, packet_crc_in;
   logic [CW-1:0] payload_count_ff, payload_count_in;
   logic [CW-1:0] accepted_len_ff, accepted_len_in;

   logic [15:0]   len_word;
   logic [15:0]   count16;
   logic [15:0]   count16_inc;
   logic [15:0]   target;
   logic          unbounded;
   logic [7:0]    crc_from_hdr;
   logic [7:0]    crc_from_pkt;
   logic [7:0]    crc_from_init;
   logic [3:0]    status;
   logic          store;

   assign len_word      = {rx_byte, length_low_ff};
   assign count16       = 16'(payload_count_ff);
   assign count16_inc   = count16 + 16'd1;
   assign unbounded     = frame_length_ff < FRAME_OVERHEAD;
   assign target        = frame_length_ff - FRAME_OVERHEAD;
   assign crc_from_hdr  = cfd_crc8_step(header_crc_ff, rx_byte, cfg.crc_poly);
   assign crc_from_pkt  = cfd_crc8_step(packet_crc_ff, rx_byte, cfg.crc_poly);
   assign crc_from_init = cfd_crc8_step(cfg.crc_init, rx_byte, cfg.crc_poly);

   always_comb begin
      phase_in         = phase_ff;
      length_low_in    = length_low_ff;
      frame_length_in  = frame_length_ff;
      header_crc_in    = header_crc_ff;
      packet_crc_in    = packet_crc_ff;
      payload_count_in = payload_count_ff;
      accepted_len_in  = accepted_len_ff;
      status           = ST_BUSY;
      store            = 1'b0;
      if (req_type == REQ_READ) begin
         status = ST_READ;
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cfg.start_marker) begin
                  header_crc_in = crc_from_init;
                  phase_in      = PH_LEN_LO;
               end else begin
                  status = ST_IGNORED;
               end
            end
            PH_LEN_LO: begin
               length_low_in = rx_byte;
               header_crc_in = crc_from_hdr;
               phase_in      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               frame_length_in = len_word;
               header_crc_in   = crc_from_hdr;
               if (len_word < cfg.min_frame_len || len_word > cfg.max_frame_len) begin
                  status           = ST_BAD_LEN;
                  phase_in         = PH_HUNT;
                  payload_count_in = '0;
                  frame_length_in  = '0;
               end else begin
                  phase_in = PH_HDR_CRC;
               end
            end
            PH_HDR_CRC: begin
               if (rx_byte != header_crc_ff) begin
                  status           = ST_HDR_CRC;
                  phase_in         = PH_HUNT;
                  payload_count_in = '0;
                  frame_length_in  = '0;
               end else begin
                  phase_in = PH_DATA_MARK;
               end
            end
            PH_DATA_MARK: begin
               if (rx_byte == cfg.data_marker) begin
                  packet_crc_in    = crc_from_init;
                  payload_count_in = '0;
                  phase_in         = PH_PAYLOAD;
               end else begin
                  status           = ST_NO_DATA;
                  phase_in         = PH_HUNT;
                  payload_count_in = '0;
                  frame_length_in  = '0;
               end
            end
            PH_PAYLOAD: begin
               if (count16 < DEPTH16 && (unbounded || count16 < target)) begin
                  store            = 1'b1;
                  payload_count_in = payload_count_ff + CW'(1);
                  packet_crc_in    = crc_from_pkt;
                  if (!unbounded && count16_inc == target) begin
                     phase_in = PH_PKT_CRC;
                  end
               end else begin
                  status           = ST_OVERFLOW;
                  phase_in         = PH_HUNT;
                  payload_count_in = '0;
                  frame_length_in  = '0;
               end
            end
            PH_PKT_CRC: begin
               if (rx_byte != packet_crc_ff) begin
                  status           = ST_PKT_CRC;
                  phase_in         = PH_HUNT;
                  payload_count_in = '0;
                  frame_length_in  = '0;
               end else begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               if (rx_byte == cfg.end_marker) begin
                  status          = ST_ACCEPT;
                  accepted_len_in = payload_count_ff;
               end else begin
                  status = ST_NO_END;
               end
               phase_in         = PH_HUNT;
               payload_count_in = '0;
               frame_length_in  = '0;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign result.status    = status;
   assign result.frame_len = 9'(accepted_len_in);
   assign result.hit       = (req_type == REQ_READ) &&
                             (16'(read_index) < 16'(accepted_len_ff)) &&
                             (16'(read_index) < DEPTH16);

   assign mem_wr_en = accept && store;
   assign mem_rd_en = accept && (req_type == REQ_READ);
   assign mem_addr  = (req_type == REQ_READ) ? AW'(read_index) : AW'(payload_count_ff);
   assign mem_wdata = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         length_low_ff    <= 8'd0;
         frame_length_ff  <= 16'd0;
         header_crc_ff    <= CRC_INIT_RESET;
         packet_crc_ff    <= CRC_INIT_RESET;
         payload_count_ff <= '0;
         accepted_len_ff  <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         length_low_ff    <= length_low_in;
         frame_length_ff  <= frame_length_in;
         header_crc_ff    <= header_crc_in;
         packet_crc_ff    <= packet_crc_in;
         payload_count_ff <= payload_count_in;
         accepted_len_ff  <= accepted_len_in;
      end
   end

endmodule
